// ----- rtl/ssfs_pkg.sv -----
// ----------------------------------------------------------------------------
// ssfs_pkg
// Shared types and constants for the sprite sheet frame stepper.
// ----------------------------------------------------------------------------
package ssfs_pkg;

  localparam int unsigned FrameW  = 7;
  localparam int unsigned TimeW   = 24;
  localparam int unsigned TexW    = 14;
  localparam int unsigned PosW    = 13;
  localparam int unsigned MaskW   = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 64;
  localparam int unsigned StepW   = 4;

  localparam logic [PosW-1:0]  PosMax      = '1;
  localparam logic [StepW-1:0] StepsWide   = 4'd14;
  localparam logic [StepW-1:0] StepsNarrow = 4'd7;

  // register reset values
  localparam logic [FrameW-1:0] RstTotalFrames = 7'd1;
  localparam logic [TimeW-1:0]  RstFrameTime   = 24'd100000;
  localparam logic              RstLoopEnable  = 1'b1;
  localparam logic [FrameW-1:0] RstSheetCols   = 7'd1;
  localparam logic [FrameW-1:0] RstSheetRows   = 7'd1;
  localparam logic [TexW-1:0]   RstTexWidth    = 14'd1;
  localparam logic [TexW-1:0]   RstTexHeight   = 14'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TOTAL_FRAMES   = 3'd0,
    REG_FRAME_TIME     = 3'd1,
    REG_LOOP_ENABLE    = 3'd2,
    REG_SHEET_COLUMNS  = 3'd3,
    REG_SHEET_ROWS     = 3'd4,
    REG_TEXTURE_WIDTH  = 3'd5,
    REG_TEXTURE_HEIGHT = 3'd6,
    REG_EVENT_MASK     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [FrameW-1:0] total_frames;
    logic [TimeW-1:0]  frame_time;
    logic              loop_enable;
    logic [FrameW-1:0] sheet_columns;
    logic [FrameW-1:0] sheet_rows;
    logic [TexW-1:0]   texture_width;
    logic [TexW-1:0]   texture_height;
    logic [MaskW-1:0]  event_frame_mask;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic              wide;
    logic [TexW-1:0]   dividend;
    logic [FrameW-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [TexW-1:0]   quot;
    logic [FrameW-1:0] rem;
  } div_res_t;

endpackage

// ----- rtl/sprite_sheet_frame_stepper.sv -----
// ----------------------------------------------------------------------------
// sprite_sheet_frame_stepper
// Frame stepper for sprite sheet animation with cell rectangle recompute.
// ----------------------------------------------------------------------------
// sequence: a beat goes S_ACC, S_CHECK, S_DONE when the frame does not advance
//   or reaches the end without looping, skips S_CHECK with fewer than two frames,
//   and otherwise runs four divider jobs of 7, 14, 14 and 7 steps, then two multiplies
// throughput: one beat at a time; the next beat is taken the cycle after the
//   result enters the output register
// reset: registers take their documented defaults, state clears to zero
module sprite_sheet_frame_stepper import ssfs_pkg::*; #(
  parameter int unsigned MAX_FRAMES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [TimeW-1:0]   elapsed_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PosW-1:0]    sprite_x_o,
  output logic [PosW-1:0]    sprite_y_o,
  output logic [TexW-1:0]    sprite_width_o,
  output logic [TexW-1:0]    sprite_height_o,
  output logic [FrameW-1:0]  frame_number_o,
  output logic               advanced_o,
  output logic               frame_event_o,
  output logic               animation_end_o
);

  localparam logic [FrameW-1:0] MaxFramesV = FrameW'(MAX_FRAMES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_CHECK,
    S_DIV_NEXT,
    S_DIV_CW,
    S_DIV_CH,
    S_DIV_POS,
    S_MUL_X,
    S_MUL_Y,
    S_DONE
  } state_e;

  cfg_t     cfg;
  div_cmd_t div_cmd;
  div_res_t div_res;

  state_e            state_q;
  logic              div_wait_q;
  logic [TimeW-1:0]  elapsed_q;
  logic [TimeW-1:0]  acc_q;
  logic [FrameW-1:0] idx_q;
  logic [FrameW-1:0] col_q;
  logic [FrameW-1:0] row_q;
  logic [PosW-1:0]   rect_x_q;
  logic [PosW-1:0]   rect_y_q;
  logic [TexW-1:0]   rect_w_q;
  logic [TexW-1:0]   rect_h_q;
  logic              adv_q;
  logic              evt_q;
  logic              end_q;
  logic              out_valid_q;

  logic [FrameW-1:0]      total_eff;
  logic [FrameW-1:0]      cols_eff;
  logic [FrameW-1:0]      rows_eff;
  logic [FrameW-1:0]      idx_inc;
  logic [TimeW:0]         acc_sum;
  logic                   in_fire;
  logic                   out_free;
  logic [FrameW-1:0]      mul_a;
  logic [TexW-1:0]        mul_b;
  logic [FrameW+TexW-1:0] mul_p;
  logic [PosW-1:0]        mul_sat;

  ssfs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ssfs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .res_o  (div_res)
  );

  assign total_eff = (cfg.total_frames > MaxFramesV) ? MaxFramesV : cfg.total_frames;
  assign cols_eff  = (cfg.sheet_columns == '0) ? 7'd1 : cfg.sheet_columns;
  assign rows_eff  = (cfg.sheet_rows == '0) ? 7'd1 : cfg.sheet_rows;
  assign idx_inc   = idx_q + 7'd1;
  assign acc_sum   = {1'b0, acc_q} + {1'b0, elapsed_q};
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // divider command follows the sequencer step
  always_comb begin
    div_cmd       = '0;
    div_cmd.start = !div_wait_q && ((state_q == S_DIV_NEXT) || (state_q == S_DIV_CW) ||
                                    (state_q == S_DIV_CH) || (state_q == S_DIV_POS));
    case (state_q)
      S_DIV_NEXT: begin
        div_cmd.dividend = {7'd0, idx_inc};
        div_cmd.divisor  = total_eff;
      end
      S_DIV_CW: begin
        div_cmd.wide     = 1'b1;
        div_cmd.dividend = cfg.texture_width;
        div_cmd.divisor  = cols_eff;
      end
      S_DIV_CH: begin
        div_cmd.wide     = 1'b1;
        div_cmd.dividend = cfg.texture_height;
        div_cmd.divisor  = rows_eff;
      end
      S_DIV_POS: begin
        div_cmd.dividend = {7'd0, idx_q};
        div_cmd.divisor  = cols_eff;
      end
      default: ;
    endcase
  end

  // one shared multiplier for the cell position
  always_comb begin
    mul_a = (state_q == S_MUL_Y) ? row_q : col_q;
    mul_b = (state_q == S_MUL_Y) ? rect_h_q : rect_w_q;
    mul_p = mul_a * mul_b;
    mul_sat = (mul_p > {8'd0, PosMax}) ? PosMax : mul_p[PosW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_wait_q  <= 1'b0;
      acc_q       <= '0;
      idx_q       <= '0;
      rect_x_q    <= '0;
      rect_y_q    <= '0;
      rect_w_q    <= '0;
      rect_h_q    <= '0;
      adv_q       <= 1'b0;
      evt_q       <= 1'b0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (div_cmd.start) begin
        div_wait_q <= 1'b1;
      end else if (div_res.done) begin
        div_wait_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            adv_q   <= 1'b0;
            evt_q   <= 1'b0;
            end_q   <= 1'b0;
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (total_eff > 7'd1) begin
            acc_q   <= acc_sum[TimeW] ? '1 : acc_sum[TimeW-1:0];
            state_q <= S_CHECK;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_CHECK: begin
          if (acc_q < cfg.frame_time) begin
            state_q <= S_DONE;
          end else if (idx_inc >= total_eff && !cfg.loop_enable) begin
            // step to one past the last frame, then hold
            if (idx_inc == total_eff) begin
              idx_q <= idx_inc;
              adv_q <= 1'b1;
              end_q <= 1'b1;
            end
            state_q <= S_DONE;
          end else begin
            state_q <= S_DIV_NEXT;
          end
        end
        S_DIV_NEXT: begin
          if (div_res.done) begin
            idx_q   <= div_res.rem;
            adv_q   <= div_res.rem != idx_q;
            evt_q   <= (div_res.rem < MaxFramesV) && cfg.event_frame_mask[div_res.rem[5:0]];
            acc_q   <= '0;
            state_q <= S_DIV_CW;
          end
        end
        S_DIV_CW: begin
          if (div_res.done) begin
            rect_w_q <= div_res.quot;
            state_q  <= S_DIV_CH;
          end
        end
        S_DIV_CH: begin
          if (div_res.done) begin
            rect_h_q <= div_res.quot;
            state_q  <= S_DIV_POS;
          end
        end
        S_DIV_POS: begin
          if (div_res.done) begin
            row_q   <= div_res.quot[FrameW-1:0];
            col_q   <= div_res.rem;
            state_q <= S_MUL_X;
          end
        end
        S_MUL_X: begin
          rect_x_q <= mul_sat;
          state_q  <= S_MUL_Y;
        end
        S_MUL_Y: begin
          rect_y_q <= mul_sat;
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      elapsed_q <= elapsed_time_i;
    end
    if (state_q == S_DONE && out_free) begin
      sprite_x_o      <= rect_x_q;
      sprite_y_o      <= rect_y_q;
      sprite_width_o  <= rect_w_q;
      sprite_height_o <= rect_h_q;
      frame_number_o  <= idx_q;
      advanced_o      <= adv_q;
      frame_event_o   <= evt_q;
      animation_end_o <= end_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= MaxFramesV)
    else $error("frame index beyond frame count limit");

  a_end_is_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !animation_end_o || advanced_o)
    else $error("end flag without advance");

  a_event_is_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !frame_event_o || advanced_o)
    else $error("event flag without advance");

  a_div_only_in_div_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.busy |-> (state_q == S_DIV_NEXT) || (state_q == S_DIV_CW) ||
                     (state_q == S_DIV_CH) || (state_q == S_DIV_POS))
    else $error("divider running outside a divide step");

endmodule

// ----- rtl/ssfs_cfg.sv -----
// ----------------------------------------------------------------------------
// ssfs_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module ssfs_cfg import ssfs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_frames     <= RstTotalFrames;
      cfg_q.frame_time       <= RstFrameTime;
      cfg_q.loop_enable      <= RstLoopEnable;
      cfg_q.sheet_columns    <= RstSheetCols;
      cfg_q.sheet_rows       <= RstSheetRows;
      cfg_q.texture_width    <= RstTexWidth;
      cfg_q.texture_height   <= RstTexHeight;
      cfg_q.event_frame_mask <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_TOTAL_FRAMES:   cfg_q.total_frames     <= cfg_wdata_i[FrameW-1:0];
        REG_FRAME_TIME:     cfg_q.frame_time       <= cfg_wdata_i[TimeW-1:0];
        REG_LOOP_ENABLE:    cfg_q.loop_enable      <= cfg_wdata_i[0];
        REG_SHEET_COLUMNS:  cfg_q.sheet_columns    <= cfg_wdata_i[FrameW-1:0];
        REG_SHEET_ROWS:     cfg_q.sheet_rows       <= cfg_wdata_i[FrameW-1:0];
        REG_TEXTURE_WIDTH:  cfg_q.texture_width    <= cfg_wdata_i[TexW-1:0];
        REG_TEXTURE_HEIGHT: cfg_q.texture_height   <= cfg_wdata_i[TexW-1:0];
        REG_EVENT_MASK:     cfg_q.event_frame_mask <= cfg_wdata_i[MaskW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/ssfs_div.sv -----
// ----------------------------------------------------------------------------
// ssfs_div
// Shared restoring divider, one quotient bit per cycle, 14 or 7 steps.
// ----------------------------------------------------------------------------
module ssfs_div import ssfs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_cmd_t cmd_i,
  output div_res_t res_o
);

  logic              busy_q;
  logic              done_q;
  logic [StepW-1:0]  cnt_q;
  logic [TexW-1:0]   dvd_q;
  logic [FrameW-1:0] rem_q;
  logic [FrameW-1:0] dsr_q;

  logic [FrameW:0]   trial;
  logic [FrameW:0]   diff;
  logic              fits;

  assign trial = {rem_q, dvd_q[TexW-1]};
  assign fits  = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.wide ? StepsWide : StepsNarrow;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // narrow operands sit in the top half so the loop starts at their msb
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dvd_q <= cmd_i.wide ? cmd_i.dividend : {cmd_i.dividend[FrameW-1:0], 7'd0};
      rem_q <= '0;
      dsr_q <= cmd_i.divisor;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[TexW-2:0], fits};
      rem_q <= fits ? diff[FrameW-1:0] : trial[FrameW-1:0];
    end
  end

  assign res_o.busy = busy_q;
  assign res_o.done = done_q;
  assign res_o.quot = dvd_q;
  assign res_o.rem  = rem_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q && !done_q)
    else $error("divider started while busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (dsr_q == '0) || (rem_q < dsr_q))
    else $error("divider remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

endmodule
